### sv/tat_pkg.sv
// tat_pkg: shared types and constants for the thermistor temperature unit.
// No dependencies.
package tat_pkg;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  localparam logic [1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [1:0] REG_LOG_REF    = 2'd1;
  localparam logic [1:0] REG_INV_BETA   = 2'd2;
  localparam logic [1:0] REG_INV_TEMP   = 2'd3;

  // Queue entry between front and back
  typedef struct packed {
    logic [11:0] avg;
  } tat_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG_INIT,
    ST_LOG_SQ,
    ST_LOG_SCALE,
    ST_LOG_SCALE2,
    ST_DIFF,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_RECIP,
    ST_DIV,
    ST_DONE
  } tat_state_t;

endpackage

### sv/tat_front.sv
// tat_front: sample ring, running sum and window average.
// Depends on tat_pkg.
module tat_front
  import tat_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] sample_mv,
  output logic        q_valid,
  input  logic        q_stall,
  output tat_item_t   q_item
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW = 12 + AW;

  logic [11:0]   ring [WINDOW];
  logic [WINDOW-1:0] ring_vld;
  logic [AW-1:0] write_slot;
  logic [SW-1:0] window_sum;
  logic [SW-1:0] sum_next;
  logic [11:0]   old;
  logic          acc;

  // One-entry output register toward the back end
  assign in_stall = q_valid && q_stall;
  assign acc      = in_valid && !in_stall;
  assign old      = ring_vld[write_slot] ? ring[write_slot] : 12'd0;
  assign sum_next = window_sum + SW'(sample_mv) - SW'(old);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld   <= '0;
      write_slot <= '0;
      window_sum <= '0;
      q_valid    <= 1'b0;
    end else begin
      if (q_valid && !q_stall) q_valid <= 1'b0;
      if (acc) begin
        ring_vld[write_slot] <= 1'b1;
        write_slot <= (write_slot == AW'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
        window_sum <= sum_next;
        q_valid    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ring[write_slot] <= sample_mv;
      q_item.avg       <= 12'(sum_next / WINDOW);
    end
  end

endmodule

### sv/tat_back.sv
// tat_back: sequential log, multiply and divide for the Beta model.
// Depends on tat_pkg.
module tat_back
  import tat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_stall,
  input  tat_item_t   q_item,
  input  logic [11:0] full_scale_mv,
  input  logic [31:0] log_ref_ratio,
  input  logic [31:0] inverse_beta,
  input  logic [31:0] inverse_ref_temp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] average_mv,
  output logic [15:0] temp_centikelvin,
  output logic        out_of_range
);

  tat_state_t state, state_next;

  logic [11:0] avg;
  logic        second;     // second logarithm in progress
  logic [11:0] lx;
  logic [32:0] m;
  logic [4:0]  cnt;
  logic [28:0] lg;         // Q5.24 log2
  logic [63:0] prod;
  logic signed [33:0] ln_a;
  logic signed [34:0] d;
  logic [34:0] mag;
  logic        neg;
  logic [63:0] q;
  logic signed [41:0] x;   // 1/T, Q0.32, wide enough for extreme settings
  logic [40:0] divisor;
  logic [40:0] rem;
  logic [39:0] dividend;
  logic [39:0] quo;
  logic [5:0]  dcnt;

  logic [3:0]  top;
  logic [65:0] sq;
  logic [11:0] diffv;
  logic [41:0] rem_sh;
  logic        out_busy;   // result waiting and not taken this cycle

  function automatic logic [3:0] top_of(input logic [11:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int i = 0; i < 12; i++) if (v[i]) t = 4'(i);
    return t;
  endfunction

  // Top set bit of the log operand
  always_comb begin
    top = 4'd0;
    for (int i = 0; i < 12; i++) if (lx[i]) top = 4'(i);
  end

  assign sq       = 66'(m) * 66'(m);
  assign diffv    = full_scale_mv - avg;
  assign rem_sh   = {rem, dividend[39]};
  assign out_busy = out_valid && out_stall;
  assign q_stall  = (state != ST_IDLE) || out_busy;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (q_valid && !out_busy) state_next = ST_LOG_INIT;
      ST_LOG_INIT:   state_next = (avg == 12'd0 || avg >= full_scale_mv) ? ST_DONE
                                                                         : ST_LOG_SQ;
      ST_LOG_SQ:     if (cnt == 5'd0) state_next = ST_LOG_SCALE;
      ST_LOG_SCALE:  state_next = ST_LOG_SCALE2;
      ST_LOG_SCALE2: state_next = second ? ST_DIFF : ST_LOG_SQ;
      ST_DIFF:       state_next = ST_MUL_HI;
      ST_MUL_HI:     state_next = ST_MUL_LO;
      ST_MUL_LO:     state_next = ST_RECIP;
      ST_RECIP:      state_next = (x <= 0) ? ST_DONE : ST_DIV;
      ST_DIV:        if (dcnt == 6'd0) state_next = ST_DONE;
      ST_DONE:       state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_DONE) out_valid <= 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        avg    <= q_item.avg;
        lx     <= q_item.avg;
        second <= 1'b0;
      end
      ST_LOG_INIT: begin
        average_mv <= avg;
        if (avg == 12'd0) begin
          temp_centikelvin <= 16'hFFFF;
          out_of_range     <= 1'b1;
        end else if (avg >= full_scale_mv) begin
          temp_centikelvin <= 16'd0;
          out_of_range     <= 1'b1;
        end else begin
          m   <= 33'(lx) << (5'd31 - 5'(top));
          lg  <= {1'b0, top, 24'd0};
          cnt <= 5'd23;
        end
      end
      ST_LOG_SQ: begin
        if (sq[62+1:31] >= 33'h100000000) begin
          m <= 33'(sq[63:32]);
          lg[cnt] <= 1'b1;
        end else begin
          m <= sq[63:31];
        end
        cnt <= cnt - 1'b1;
      end
      ST_LOG_SCALE: prod <= 64'(lg) * LN2_Q32;
      ST_LOG_SCALE2: begin
        if (!second) begin
          ln_a   <= 34'(signed'({1'b0, (prod + 64'h80000000) >> 32}));
          lx     <= diffv;
          second <= 1'b1;
          m   <= 33'(diffv) << (5'd31 - 5'(top_of(diffv)));
          lg  <= {1'b0, top_of(diffv), 24'd0};
          cnt <= 5'd23;
        end else begin
          d <= 35'(ln_a) - 35'(signed'({1'b0, 32'((prod + 64'h80000000) >> 32)}))
               - 35'(signed'(log_ref_ratio));
        end
      end
      ST_DIFF: begin
        neg <= d[34];
        mag <= d[34] ? 35'(-d) : 35'(d);
      end
      ST_MUL_HI: q <= 64'(mag) * 64'(inverse_beta[31:16]);
      ST_MUL_LO: begin
        x <= neg ? 42'(inverse_ref_temp) - 42'((q + ((64'(mag) * 64'(inverse_beta[15:0]))
                                                   >> 16)) >> 8)
                 : 42'(inverse_ref_temp) + 42'((q + ((64'(mag) * 64'(inverse_beta[15:0]))
                                                   >> 16)) >> 8);
      end
      ST_RECIP: begin
        if (x <= 0) begin
          temp_centikelvin <= 16'hFFFF;
          out_of_range     <= 1'b1;
        end else begin
          divisor  <= 41'(x);
          dividend <= 40'(64'd100 << 32) + 40'(x[41:1]);
          rem      <= '0;
          quo      <= '0;
          dcnt     <= 6'd39;
        end
      end
      ST_DIV: begin
        if (rem_sh >= 42'(divisor)) begin
          rem <= 41'(rem_sh - 42'(divisor));
          quo <= {quo[38:0], 1'b1};
        end else begin
          rem <= rem_sh[40:0];
          quo <= {quo[38:0], 1'b0};
        end
        dividend <= dividend << 1;
        dcnt <= dcnt - 1'b1;
        if (dcnt == 6'd0) begin
          if (rem_sh >= 42'(divisor)) begin
            temp_centikelvin <= (quo[38:15] != 0) ? 16'hFFFF : {quo[14:0], 1'b1};
            out_of_range     <= quo[38:15] != 0;
          end else begin
            temp_centikelvin <= (quo[38:15] != 0) ? 16'hFFFF : {quo[14:0], 1'b0};
            out_of_range     <= quo[38:15] != 0;
          end
        end
      end
      default: ;
    endcase
  end

  // Back end starts only when the output register is free by the next edge
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && state_next == ST_LOG_INIT) |-> !out_busy)
    else $error("start with result pending");
  a_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> out_valid)
    else $error("result not posted");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(temp_centikelvin))
    else $error("result changed while stalled");

endmodule

### sv/thermistor_average_to_temperature_unit.sv
// Thermistor moving average and Beta-model temperature, top level.
// The result follows two 24-step log loops and a 40-step serial divider; all
// three are skipped when the average is zero or at or above full scale, and
// the divider is skipped when the reciprocal is not positive.
// The back end takes one transaction at a time; front register holds one more.
// Synchronous active-high reset invalidates the ring, clears sum, slot and valid flags, and loads config defaults.
module thermistor_average_to_temperature_unit
  import tat_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] sample_mv,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] average_mv,
  output logic [15:0] temp_centikelvin,
  output logic        out_of_range
);

  logic [11:0] full_scale_mv;
  logic [31:0] log_ref_ratio, inverse_beta, inverse_ref_temp;
  logic        q_valid, q_stall;
  tat_item_t   q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_mv    <= 12'd2500;
      log_ref_ratio    <= 32'd0;
      inverse_beta     <= 32'd1087352;
      inverse_ref_temp <= 32'd14405391;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FULL_SCALE: full_scale_mv    <= cfg_data[11:0];
        REG_LOG_REF:    log_ref_ratio    <= cfg_data;
        REG_INV_BETA:   inverse_beta     <= cfg_data;
        REG_INV_TEMP:   inverse_ref_temp <= cfg_data;
        default: ;
      endcase
    end
  end

  tat_front #(.WINDOW(WINDOW)) u_front (
    .clk, .rst, .in_valid, .in_stall, .sample_mv,
    .q_valid, .q_stall, .q_item
  );

  tat_back u_back (
    .clk, .rst, .q_valid, .q_stall, .q_item,
    .full_scale_mv, .log_ref_ratio, .inverse_beta, .inverse_ref_temp,
    .out_valid, .out_stall, .average_mv, .temp_centikelvin, .out_of_range
  );

endmodule
